// File: hw/rtl/tnpg_pkg.sv
// Package for the tensor noise pattern generator: codes, constants and the
// control word that travels between the pipeline and the element encoder.
// Depends on nothing; every other file of the block imports it.
package tnpg_pkg;

	// Operation codes carried by the func field.
	typedef enum logic [1:0] {
		FUNC_START   = 2'd0,
		FUNC_PAYLOAD = 2'd1,
		FUNC_SCALE   = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	// Weight format codes latched at tensor start.
	typedef enum logic [1:0] {
		FMT_BF16  = 2'd0,
		FMT_F32   = 2'd1,
		FMT_MXFP4 = 2'd2,
		FMT_FP8   = 2'd3
	} fmt_t;

	// Control word for one element in flight.
	typedef struct packed {
		func_t func;
		fmt_t  fmt;
	} elem_ctrl_t;

	// Seeding and generator constants.
	localparam logic [63:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] LAYER_MUL  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] ZERO_SUBST = 64'h2545f4914f6cdd1d;
	localparam logic [63:0] STAR_MUL   = 64'd2685821657736338717;
	localparam logic [63:0] SEED_RESET = 64'd1;

	// Biased exponents of a value m * 2^(e - shift): 127 - 18 and 127 - 20.
	localparam logic [7:0] EXP_OFS_F32  = 8'd109;
	localparam logic [7:0] EXP_OFS_BF16 = 8'd107;

	// Scale encodings.
	localparam logic [7:0] SCALE_BYTE_BASE = 8'd120;
	localparam logic [7:0] SCALE_FP8_BASE  = 8'h3f;
	localparam logic [7:0] SCALE_FP8_MID   = 8'h80;

	// Valid byte counts of an element.
	localparam logic [2:0] BYTES_1 = 3'd1;
	localparam logic [2:0] BYTES_2 = 3'd2;
	localparam logic [2:0] BYTES_4 = 3'd4;

	// One xorshift64 state step.
	function automatic logic [63:0] xorshift_step(input logic [63:0] x_in);
		logic [63:0] x;
		x = x_in;
		x = x ^ (x >> 12);
		x = x ^ (x << 25);
		x = x ^ (x >> 27);
		return x;
	endfunction

endpackage

// File: hw/rtl/tensor_noise_pattern_generator.sv
// Top level of the tensor noise pattern generator: xorshift64* state,
// element pipeline and output register. Uses tnpg_pkg, tnpg_seed, tnpg_encode.
//
//   port group    direction  handshake            payload
//   input word    in         in_valid / in_stall  func, tensor_id, layer_num, elem_format
//   result word   out        out_valid/ out_stall element_data, element_bytes
//   seed_base     in         cfg_wr_en            cfg_wr_data
//
// Element words are taken one per cycle unless in_stall holds them; a result
// passes the s1 and s2 registers and the output register. For a start word the seed
// multiply is split into registered partial products and the state loads next cycle.
// Reset clears the state to zero, the format to bf16 and seed_base to one.
// A stalled result freezes the whole pipeline; the input stalls only then or
// while a seed is being formed.
module tensor_noise_pattern_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  tensor_id,
	input  logic [31:0] layer_num,
	input  logic [1:0]  elem_format,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] element_data,
	output logic [2:0]  element_bytes
);
	import tnpg_pkg::*;

	logic [63:0] seed_base_q;
	logic [63:0] state_q;
	fmt_t        fmt_q;
	logic        advance;
	logic        in_accept;
	logic        start_acc;
	logic        elem_acc;
	logic        seed_busy;
	logic [63:0] seed;
	logic [63:0] state_next;
	logic        valid_s1;
	logic [15:0] x_s1;
	elem_ctrl_t  ctrl_s1;
	logic        valid_s2;
	logic [15:0] rnd_s2;
	elem_ctrl_t  ctrl_s2;
	logic        out_valid_q;
	logic [31:0] data_q;
	logic [2:0]  bytes_q;
	logic [31:0] enc_data;
	logic [2:0]  enc_bytes;

	// Pipeline moves whenever the output register is free.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = !advance || seed_busy;
	assign in_accept = in_valid && !in_stall;
	assign start_acc = in_accept && (func_t'(func) == FUNC_START);
	assign elem_acc  = in_accept
		&& (func_t'(func) == FUNC_PAYLOAD || func_t'(func) == FUNC_SCALE);
	assign state_next = xorshift_step(state_q);

	// Base seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_base_q <= SEED_RESET;
		end else if (cfg_wr_en) begin
			seed_base_q <= cfg_wr_data;
		end
	end

	tnpg_seed u_seed (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_acc),
		.tensor_id (tensor_id),
		.layer_num (layer_num),
		.seed_base (seed_base_q),
		.busy      (seed_busy),
		.seed      (seed)
	);

	// Generator state and latched format.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 64'd0;
			fmt_q   <= FMT_BF16;
		end else begin
			if (seed_busy) begin
				state_q <= seed;
			end else if (elem_acc) begin
				state_q <= state_next;
			end
			if (start_acc) begin
				fmt_q <= fmt_t'(elem_format);
			end
		end
	end

	// Pipeline valid bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= elem_acc;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Payload stages: low 16 bits of the new state word, low 16 bits of the star product, element.
	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1         <= state_next[15:0];
			ctrl_s1.func <= func_t'(func);
			ctrl_s1.fmt  <= fmt_q;
			rnd_s2       <= 16'(x_s1 * STAR_MUL[15:0]);
			ctrl_s2      <= ctrl_s1;
			data_q       <= enc_data;
			bytes_q      <= enc_bytes;
		end
	end

	tnpg_encode u_encode (
		.ctrl   (ctrl_s2),
		.rnd    (rnd_s2),
		.data   (enc_data),
		.nbytes (enc_bytes)
	);

	assign out_valid     = out_valid_q;
	assign element_data  = data_q;
	assign element_bytes = bytes_q;

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		seed_busy |-> in_stall)
		else $error("input accepted while seed is formed");
	a_elem_enters: assert property (@(posedge clk) disable iff (!arst_n)
		elem_acc |=> valid_s1)
		else $error("accepted element did not enter the pipeline");
	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc |=> !valid_s1)
		else $error("start word produced a result");
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bytes_q == BYTES_1 || bytes_q == BYTES_2 || bytes_q == BYTES_4))
		else $error("illegal element byte count");
`endif

endmodule

// File: hw/rtl/tnpg_seed.sv
// Seed unit: forms the generator seed of a tensor from the base seed, the
// tensor kind and the layer index, from registered partial products. Uses tnpg_pkg.
module tnpg_seed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [7:0]  tensor_id,
	input  logic [31:0] layer_num,
	input  logic [63:0] seed_base,
	output logic        busy,
	output logic [63:0] seed
);
	import tnpg_pkg::*;

	logic [8:0]  kind_inc;
	logic [31:0] layer_inc;
	logic [40:0] gold_lo_q;
	logic [31:0] gold_hi_q;
	logic [63:0] layer_lo_q;
	logic [31:0] layer_hi_q;
	logic        busy_q;
	logic [63:0] gold_prod;
	logic [63:0] layer_prod;
	logic [63:0] mixed;

	// Increments; the layer increment wraps within 32 bits.
	assign kind_inc  = {1'b0, tensor_id} + 9'd1;
	assign layer_inc = layer_num + 32'd1;

	// Partial products of the two 64-bit constant multiplies, registered.
	always_ff @(posedge clk) begin
		if (start) begin
			gold_lo_q  <= 41'(GOLDEN_MUL[31:0] * kind_inc);
			gold_hi_q  <= 32'(GOLDEN_MUL[63:32] * {23'd0, kind_inc});
			layer_lo_q <= 64'(LAYER_MUL[31:0] * layer_inc);
			layer_hi_q <= 32'(LAYER_MUL[63:32] * layer_inc);
		end
	end

	// The seed is ready in the cycle after the start word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	// Sum the partial products and mix; a zero seed is replaced.
	assign gold_prod  = {23'd0, gold_lo_q} + {gold_hi_q, 32'd0};
	assign layer_prod = layer_lo_q + {layer_hi_q, 32'd0};
	assign mixed      = seed_base ^ gold_prod ^ layer_prod;
	assign seed       = (mixed == 64'd0) ? ZERO_SUBST : mixed;
	assign busy       = busy_q;

`ifndef SYNTHESIS
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q || $past(start))
		else $error("seed busy held without a new start");
	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("start did not raise seed busy");
	a_seed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> seed != 64'd0)
		else $error("seed of zero delivered");
`endif

endmodule

// File: hw/rtl/tnpg_encode.sv
// Element encoder: turns the low 16 bits of the generator output into one
// payload or scale element for the latched format. Uses tnpg_pkg.
module tnpg_encode (
	input  tnpg_pkg::elem_ctrl_t ctrl,
	input  logic [15:0]          rnd,
	output logic [31:0]          data,
	output logic [2:0]           nbytes
);
	import tnpg_pkg::*;

	logic        neg;
	logic [15:0] mag;
	logic [3:0]  lead;
	logic [15:0] norm;
	logic [31:0] f32_word;
	logic [31:0] bf16_word;
	logic        is_zero;

	// Offset value rnd - 32768 as sign and magnitude.
	assign neg     = ~rnd[15];
	assign mag     = neg ? (16'h8000 - rnd) : {1'b0, rnd[14:0]};
	assign is_zero = (rnd == 16'h8000);

	// Position of the leading one of the magnitude.
	always_comb begin
		lead = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) begin
				lead = 4'(i);
			end
		end
	end

	// Normalize so that the leading one sits in bit 15; the bits below it
	// form the top of the mantissa.
	assign norm = mag << (4'd15 - lead);

	// Float words for both scalings; zero encodes as positive zero.
	assign f32_word  = is_zero ? 32'd0
		: {neg, EXP_OFS_F32 + {4'd0, lead}, norm[14:0], 8'd0};
	assign bf16_word = is_zero ? 32'd0
		: {16'd0, neg, EXP_OFS_BF16 + {4'd0, lead}, norm[14:8]};

	// Select the element by region and format.
	always_comb begin
		data   = 32'd0;
		nbytes = BYTES_1;
		if (ctrl.func == FUNC_SCALE) begin
			if (ctrl.fmt == FMT_FP8) begin
				data   = {SCALE_FP8_BASE + {5'd0, rnd[2:0]}, SCALE_FP8_MID, 16'd0};
				nbytes = BYTES_4;
			end else begin
				data   = {24'd0, SCALE_BYTE_BASE + {5'd0, rnd[2:0]}};
				nbytes = BYTES_1;
			end
		end else begin
			case (ctrl.fmt)
				FMT_MXFP4: begin
					data   = {24'd0, rnd[7:0]};
					nbytes = BYTES_1;
				end
				FMT_F32: begin
					data   = f32_word;
					nbytes = BYTES_4;
				end
				default: begin
					data   = bf16_word;
					nbytes = BYTES_2;
				end
			endcase
		end
	end

endmodule

// File: verif/tensor_noise_pattern_generator_test.sv
`timescale 1ns / 100ps

// Self-checking bench for tensor_noise_pattern_generator: a directed table, then random
// tensor sequences under several seed_base values, every result checked against an expected element.
// Depends on tnpg_pkg and the generator RTL only.
module tensor_noise_pattern_generator_test;
	import tnpg_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int NUM_PHASES      = 6;
	localparam int SETTLE_CYCLES   = 8;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
	} element_t;

	// One input word; known rows carry their expected element typed in.
	typedef struct {
		func_t       op;
		logic [7:0]  kind;
		logic [31:0] layer;
		fmt_t        fmt;
		bit          known;
		logic [31:0] data;
		logic [2:0]  nbytes;
	} stim_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic [63:0] cfg_wr_data   = '0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [1:0]  func          = FUNC_NONE;
	logic [7:0]  tensor_id     = '0;
	logic [31:0] layer_num     = '0;
	logic [1:0]  elem_format   = FMT_BF16;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [31:0] element_data;
	logic [2:0]  element_bytes;

	// Predictor state: register copy, generator state and latched format.
	logic [63:0] seed_reg   = SEED_RESET;
	logic [63:0] gen_state  = '0;
	fmt_t        gen_format = FMT_BF16;

	element_t pending_elements[$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       stall_left     = 0;
	bit       tx_idle_en     = 1'b1;
	bit       rx_idle_en     = 1'b1;

	tensor_noise_pattern_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.tensor_id     (tensor_id),
		.layer_num     (layer_num),
		.elem_format   (elem_format),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.element_data  (element_data),
		.element_bytes (element_bytes)
	);

	// Seed of a tensor from the base seed and its kind and layer; zero is replaced.
	function automatic logic [63:0] tensor_seed(input logic [63:0] base, input logic [7:0] kind,
			input logic [31:0] layer);
		logic [31:0] layer_next;
		logic [63:0] mix;
		layer_next = layer + 32'd1;
		mix = base ^ (GOLDEN_MUL * ({56'd0, kind} + 64'd1)) ^ (LAYER_MUL * {32'd0, layer_next});
		return (mix == 64'd0) ? ZERO_SUBST : mix;
	endfunction

	function automatic logic [63:0] xorshift_next(input logic [63:0] cur);
		logic [63:0] v;
		v = cur ^ (cur >> 12);
		v = v ^ (v << 25);
		return v ^ (v >> 27);
	endfunction

	// The f32 word of (low - 32768) scaled by a power of two; the biased exponent of
	// the leading one is exp_ofs plus its position, so the word is always exact.
	function automatic logic [31:0] noise_bits(input logic [15:0] low, input logic [7:0] exp_ofs);
		logic        neg;
		logic [15:0] mag;
		logic [31:0] frac;
		int          msb;
		int          i;
		neg = (low < 16'h8000);
		mag = neg ? (16'h8000 - low) : (low - 16'h8000);
		if (mag == 16'd0)
			return 32'd0;
		msb = 0;
		for (i = 0; i < 16; i++)
			if (mag[i])
				msb = i;
		frac = {16'd0, mag} << (23 - msb);
		return {neg, exp_ofs + 8'(msb), frac[22:0]};
	endfunction

	// Encoding of one element from the generator output r.
	function automatic element_t encode_element(input func_t op, input fmt_t fmt,
			input logic [63:0] r);
		element_t el;
		logic [31:0] word;
		if (op == FUNC_PAYLOAD) begin
			case (fmt)
				FMT_MXFP4: begin
					el.data   = {24'd0, r[7:0]};
					el.nbytes = BYTES_1;
				end
				FMT_F32: begin
					el.data   = noise_bits(r[15:0], EXP_OFS_F32);
					el.nbytes = BYTES_4;
				end
				default: begin
					word      = noise_bits(r[15:0], EXP_OFS_BF16);
					el.data   = {16'd0, word[31:16]};
					el.nbytes = BYTES_2;
				end
			endcase
		end else if (fmt == FMT_FP8) begin
			el.data   = {SCALE_FP8_BASE + {5'd0, r[2:0]}, SCALE_FP8_MID, 16'h0000};
			el.nbytes = BYTES_4;
		end else begin
			el.data   = {24'd0, SCALE_BYTE_BASE + {5'd0, r[2:0]}};
			el.nbytes = BYTES_1;
		end
		return el;
	endfunction

	// Applies one accepted word to the predictor and tells whether it makes an element.
	task automatic model_word(input stim_row_t row, output bit produces, output element_t el);
		logic [63:0] r;
		produces  = 1'b0;
		el.data   = '0;
		el.nbytes = '0;
		case (row.op)
			FUNC_START: begin
				gen_state  = tensor_seed(seed_reg, row.kind, row.layer);
				gen_format = row.fmt;
			end
			FUNC_PAYLOAD, FUNC_SCALE: begin
				gen_state = xorshift_next(gen_state);
				r         = gen_state * STAR_MUL;
				el        = encode_element(row.op, gen_format, r);
				produces  = 1'b1;
			end
			default: ;
		endcase
	endtask

	// First layer whose opening element has the wanted low 16 bits of r.
	function automatic logic [31:0] layer_for_low(input logic [63:0] base, input logic [7:0] kind,
			input logic [15:0] want);
		logic [31:0] layer;
		logic [63:0] r;
		layer = 32'd0;
		r = xorshift_next(tensor_seed(base, kind, layer)) * STAR_MUL;
		while (r[15:0] != want) begin
			layer = layer + 32'd1;
			r = xorshift_next(tensor_seed(base, kind, layer)) * STAR_MUL;
		end
		return layer;
	endfunction

	// Start word with fields biased toward their extremes.
	function automatic stim_row_t random_start();
		stim_row_t row;
		row.op = FUNC_START;
		case ($urandom_range(0, 7))
			0: row.kind = 8'h00;
			1: row.kind = 8'hff;
			default: row.kind = 8'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: row.layer = 32'hffff_ffff;
			1: row.layer = 32'd0;
			2, 3: row.layer = $urandom_range(0, 95);
			default: row.layer = $urandom;
		endcase
		row.fmt    = fmt_t'($urandom_range(0, 3));
		row.known  = 1'b0;
		row.data   = '0;
		row.nbytes = '0;
		return row;
	endfunction

	function automatic void note_mismatch(input string what, input element_t want,
			input element_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected data %h bytes %0d, got data %h bytes %0d", $time, what,
				want.data, want.nbytes, got.data, got.nbytes);
	endfunction

	// Drives one word, with an occasional gap first, and waits for it to be taken.
	// Called at a rising edge; returns at the edge that accepted the word.
	task automatic send_row(input stim_row_t row);
		bit       produces;
		element_t el;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= row.op;
		tensor_id   <= row.kind;
		layer_num   <= row.layer;
		elem_format <= row.fmt;
		do
			@(posedge clk);
		while (in_stall);
		model_word(row, produces, el);
		if (produces) begin
			if (row.known) begin
				el.data   = row.data;
				el.nbytes = row.nbytes;
			end
			pending_elements.push_back(el);
		end
	endtask

	// Holds the sender off until every expected element has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_elements.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls come in bursts, started at random while rx_idle_en is set.
	always @(posedge clk) begin : receiver_stalls
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Each accepted word is compared with the oldest expected element.
	always @(posedge clk) begin : check_results
		element_t want;
		element_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.data   = element_data;
			got.nbytes = element_bytes;
			if (pending_elements.size() == 0) begin
				want.data   = '0;
				want.nbytes = '0;
				note_mismatch("word with nothing expected", want, got);
			end else begin
				want = pending_elements.pop_front();
				if (got.data !== want.data)
					note_mismatch("element_data", want, got);
				if (got.nbytes !== want.nbytes)
					note_mismatch("element_bytes", want, got);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t   directed_rows[$];
		stim_row_t   row;
		logic [31:0] zero_layer;
		logic [31:0] peak_layer;
		logic [63:0] phase_seed;
		int          phase;
		int          placed;
		int          burst;
		int          k;
		bit          drained;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Layers whose first element lands on a zero value and on the largest positive one.
		zero_layer = layer_for_low(seed_reg, 8'h33, 16'h8000);
		peak_layer = layer_for_low(seed_reg, 8'h44, 16'hffff);

		// Before any start the state stays zero, so r is zero and the value is -2^-5.
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_BF16, 1'b1, 32'h0000_bd00,
			BYTES_2});
		directed_rows.push_back('{FUNC_SCALE, 8'hff, 32'hffff_ffff, FMT_FP8, 1'b1, 32'h78,
			BYTES_1});
		// An unused code must leave the format and state alone.
		directed_rows.push_back('{FUNC_NONE, 8'hff, 32'hffff_ffff, FMT_FP8, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'h00, 32'h0, FMT_F32, 1'b1, 32'h78, BYTES_1});
		directed_rows.push_back('{FUNC_START, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		// Layer sentinel wraps to zero; f32 scale falls back to the byte form.
		directed_rows.push_back('{FUNC_START, 8'hff, 32'hffff_ffff, FMT_F32, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_START, 8'h5a, 32'h7, FMT_MXFP4, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_F32, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'h00, 32'h0, FMT_F32, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_START, 8'h01, 32'h8000_0000, FMT_FP8, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_SCALE, 8'hff, 32'hffff_ffff, FMT_MXFP4, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_NONE, 8'h00, 32'h0, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_MXFP4, 1'b0, 32'h0, 3'd0});
		// A zero value is positive zero in both float forms.
		directed_rows.push_back('{FUNC_START, 8'h33, zero_layer, FMT_F32, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_BF16, 1'b1, 32'h0, BYTES_4});
		directed_rows.push_back('{FUNC_START, 8'h33, zero_layer, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_F32, 1'b1, 32'h0, BYTES_2});
		directed_rows.push_back('{FUNC_START, 8'h44, peak_layer, FMT_BF16, 1'b0, 32'h0, 3'd0});
		directed_rows.push_back('{FUNC_PAYLOAD, 8'h00, 32'h0, FMT_F32, 1'b0, 32'h0, 3'd0});

		foreach (directed_rows[i])
			send_row(directed_rows[i]);

		// Random phases, each under its own seed_base; the last one runs without idling.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: phase_seed = GOLDEN_MUL ^ LAYER_MUL;
				1: phase_seed = 64'd0;
				2: phase_seed = '1;
				default: phase_seed = {$urandom, $urandom};
			endcase
			tx_idle_en = (phase < NUM_PHASES - 1) && (phase != 2);
			rx_idle_en = (phase < NUM_PHASES - 1);

			// The register is written only once the block has gone quiet.
			drain_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= phase_seed;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			seed_reg = phase_seed;

			// Kind 0 at layer 0 opens each phase; under the first seed its mix is zero and is replaced.
			row       = random_start();
			row.kind  = 8'h00;
			row.layer = 32'd0;
			send_row(row);
			placed  = 1;
			drained = 1'b0;

			while (placed < ITEMS_PER_PHASE) begin
				if (!drained && placed >= ITEMS_PER_PHASE / 2) begin
					drain_results();
					drained = 1'b1;
				end
				// Mostly a start followed by a run of elements; now and then an ignored word.
				row = random_start();
				if ($urandom_range(0, 9) == 0)
					row.op = FUNC_NONE;
				else
					placed++;
				send_row(row);
				burst = $urandom_range(0, 40);
				for (k = 0; k < burst; k++) begin
					row = random_start();
					if ($urandom_range(0, 19) == 0) begin
						row.op = FUNC_NONE;
					end else begin
						row.op = ($urandom_range(0, 4) == 0) ? FUNC_SCALE : FUNC_PAYLOAD;
						placed++;
					end
					send_row(row);
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_elements.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: tensor_noise_pattern_generator.f
hw/rtl/tnpg_pkg.sv
hw/rtl/tnpg_seed.sv
hw/rtl/tnpg_encode.sv
hw/rtl/tensor_noise_pattern_generator.sv
verif/tensor_noise_pattern_generator_test.sv
